@@ hdl/ccfp_pkg.sv @@
// shared constants and types for the circumcircle pipeline
package ccfp_pkg;

    localparam int              TOL_W     = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

    // how one centre coordinate is formed
    typedef enum logic [1:0] {
        KIND_MID,
        KIND_BIS,
        KIND_GEN
    } t_kind;

    // point pair of an axis-aligned chord
    typedef enum logic [1:0] {
        PAIR_12,
        PAIR_20,
        PAIR_01
    } t_pair;

    // chord whose perpendicular bisector is used
    typedef enum logic {
        CHORD_20,
        CHORD_12
    } t_chord;

endpackage

@@ hdl/circumcircle_from_three_points_unit.sv @@
// Circumcircle pipeline top level. Takes three points per beat on the input stream and returns
// the centre and radius of the circle through them, plus degenerate and saturated flags. One beat
// is accepted every cycle while the output is not stalled. The pipe is an eight-stage front end
// of chord tests and partial products, then two bit-per-stage dividers (COORD_WIDTH+2 stages),
// radius stages and a bit-per-stage square root (COORD_WIDTH+2 stages). The whole pipe holds
// while the output beat waits. The user must write the axis tolerance register only while the
// pipe is empty; the block itself does not enforce it.
module circumcircle_from_three_points_unit
    import ccfp_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_wr_en,
    input  logic [TOL_W-1:0]                            i_cfg_wr_data,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // center_x, center_y, radius
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
    // degenerate, saturated
    output logic [1:0]                                  m_axis_tuser
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = 2 * W + 4;
    localparam int NW  = 3 * W + 6;
    localparam int L   = W + 2;
    localparam int LAT = W + 2;
    localparam int SQ  = W + 2;
    localparam int RW  = 2 * W + 4;
    localparam int OW  = ((3 * W + 7) / 8) * 8;

    typedef struct packed {
        logic                deg;
        logic signed [W-1:0] x0;
        logic signed [W-1:0] y0;
    } t_dly;

    typedef struct packed {
        logic                deg;
        logic                sat;
        logic signed [W-1:0] cx;
        logic signed [W-1:0] cy;
    } t_side;

    logic w_adv;
    logic [TOL_W-1:0] r_tol;

    logic [7:0]     r_fv;
    logic [LAT-1:0] r_dv;
    logic [2:0]     r_rv;
    logic [SQ-1:0]  r_sv;
    logic           r_ov;

    assign w_adv         = !r_ov || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_dv <= '0;
            r_rv <= '0;
            r_sv <= '0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_fv <= {r_fv[6:0], s_axis_tvalid};
            r_dv <= {r_dv[LAT-2:0], r_fv[7]};
            r_rv <= {r_rv[1:0], r_dv[LAT-1]};
            r_sv <= {r_sv[SQ-2:0], r_rv[2]};
            r_ov <= r_sv[SQ-1];
        end
    end

    // stage 1: input registers
    logic signed [W-1:0] r_s1_x [3];
    logic signed [W-1:0] r_s1_y [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_x[i] <= s_axis_tdata[2*i*W +: W];
                r_s1_y[i] <= s_axis_tdata[(2*i+1)*W +: W];
            end
        end
    end

    // stage 2: chord tests and edge vectors
    // flag order: v12, v20, v01, h12, h20, h01
    logic signed [W:0] w_dif [6];
    logic [W:0]        w_mag [6];
    logic [5:0]        w_flag;

    always_comb begin
        w_dif[0] = (W+1)'(r_s1_x[1]) - (W+1)'(r_s1_x[2]);
        w_dif[1] = (W+1)'(r_s1_x[2]) - (W+1)'(r_s1_x[0]);
        w_dif[2] = (W+1)'(r_s1_x[0]) - (W+1)'(r_s1_x[1]);
        w_dif[3] = (W+1)'(r_s1_y[1]) - (W+1)'(r_s1_y[2]);
        w_dif[4] = (W+1)'(r_s1_y[2]) - (W+1)'(r_s1_y[0]);
        w_dif[5] = (W+1)'(r_s1_y[0]) - (W+1)'(r_s1_y[1]);
        for (int i = 0; i < 6; i++) begin
            w_mag[i]  = w_dif[i][W] ? (W+1)'(-w_dif[i]) : (W+1)'(w_dif[i]);
            w_flag[i] = w_mag[i] < (W+1)'(r_tol);
        end
    end

    logic [5:0]          r_s2_f;
    logic signed [W-1:0] r_s2_x [3];
    logic signed [W-1:0] r_s2_y [3];
    logic signed [W:0]   r_s2_bx, r_s2_by, r_s2_qx, r_s2_qy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_f  <= w_flag;
            r_s2_x  <= r_s1_x;
            r_s2_y  <= r_s1_y;
            r_s2_bx <= (W+1)'(r_s1_x[1]) - (W+1)'(r_s1_x[0]);
            r_s2_by <= (W+1)'(r_s1_y[1]) - (W+1)'(r_s1_y[0]);
            r_s2_qx <= (W+1)'(r_s1_x[2]) - (W+1)'(r_s1_x[0]);
            r_s2_qy <= (W+1)'(r_s1_y[2]) - (W+1)'(r_s1_y[0]);
        end
    end

    // stage 3: branch decode, operand selection, squares
    t_kind  w_xk, w_yk;
    t_pair  w_xp, w_yp;
    t_chord w_ch;
    logic   w_bis_y;
    logic signed [W:0]   w_mxs, w_mys, w_s;
    logic signed [W-1:0] w_u [3];
    logic signed [W-1:0] w_v [3];
    logic signed [W-1:0] w_ua, w_va, w_ub, w_vb;

    always_comb begin
        w_xk    = KIND_MID;
        w_yk    = KIND_MID;
        w_xp    = PAIR_12;
        w_yp    = PAIR_12;
        w_ch    = CHORD_20;
        w_bis_y = 1'b0;
        if (r_s2_f[0] && r_s2_f[4]) begin
            w_xp = PAIR_20; w_yp = PAIR_12;
        end else if (r_s2_f[1] && r_s2_f[5]) begin
            w_xp = PAIR_01; w_yp = PAIR_20;
        end else if (r_s2_f[2] && r_s2_f[3]) begin
            w_xp = PAIR_12; w_yp = PAIR_01;
        end else if (r_s2_f[3] && r_s2_f[1]) begin
            w_xp = PAIR_12; w_yp = PAIR_20;
        end else if (r_s2_f[4] && r_s2_f[2]) begin
            w_xp = PAIR_20; w_yp = PAIR_01;
        end else if (r_s2_f[5] && r_s2_f[0]) begin
            w_xp = PAIR_01; w_yp = PAIR_12;
        end else if (r_s2_f[0]) begin
            w_xk = KIND_BIS; w_ch = CHORD_20; w_yp = PAIR_12;
        end else if (r_s2_f[1]) begin
            w_xk = KIND_BIS; w_ch = CHORD_12; w_yp = PAIR_20;
        end else if (r_s2_f[2]) begin
            w_xk = KIND_BIS; w_ch = CHORD_12; w_yp = PAIR_01;
        end else if (r_s2_f[3]) begin
            w_yk = KIND_BIS; w_ch = CHORD_20; w_xp = PAIR_12; w_bis_y = 1'b1;
        end else if (r_s2_f[4]) begin
            w_yk = KIND_BIS; w_ch = CHORD_12; w_xp = PAIR_20; w_bis_y = 1'b1;
        end else if (r_s2_f[5]) begin
            w_yk = KIND_BIS; w_ch = CHORD_12; w_xp = PAIR_01; w_bis_y = 1'b1;
        end else begin
            w_xk = KIND_GEN; w_yk = KIND_GEN;
        end

        case (w_xp)
            PAIR_12: w_mxs = (W+1)'(r_s2_x[1]) + (W+1)'(r_s2_x[2]);
            PAIR_20: w_mxs = (W+1)'(r_s2_x[2]) + (W+1)'(r_s2_x[0]);
            PAIR_01: w_mxs = (W+1)'(r_s2_x[0]) + (W+1)'(r_s2_x[1]);
            default: w_mxs = '0;
        endcase
        case (w_yp)
            PAIR_12: w_mys = (W+1)'(r_s2_y[1]) + (W+1)'(r_s2_y[2]);
            PAIR_20: w_mys = (W+1)'(r_s2_y[2]) + (W+1)'(r_s2_y[0]);
            PAIR_01: w_mys = (W+1)'(r_s2_y[0]) + (W+1)'(r_s2_y[1]);
            default: w_mys = '0;
        endcase

        // u is the axis being solved, v the axis fixed by the aligned chord
        for (int i = 0; i < 3; i++) begin
            w_u[i] = w_bis_y ? r_s2_y[i] : r_s2_x[i];
            w_v[i] = w_bis_y ? r_s2_x[i] : r_s2_y[i];
        end
        w_s = w_bis_y ? w_mxs : w_mys;
        case (w_ch)
            CHORD_20: begin
                w_ua = w_u[2]; w_va = w_v[2]; w_ub = w_u[0]; w_vb = w_v[0];
            end
            CHORD_12: begin
                w_ua = w_u[1]; w_va = w_v[1]; w_ub = w_u[2]; w_vb = w_v[2];
            end
            default: begin
                w_ua = '0; w_va = '0; w_ub = '0; w_vb = '0;
            end
        endcase
    end

    t_kind               r_s3_xk, r_s3_yk;
    logic signed [W:0]   r_s3_mxs, r_s3_mys, r_s3_s;
    logic signed [W-1:0] r_s3_ua, r_s3_va, r_s3_ub, r_s3_vb;
    logic signed [W:0]   r_s3_bx, r_s3_by, r_s3_qx, r_s3_qy;
    // bx^2, by^2, qx^2, qy^2, bx*qy, by*qx
    logic signed [2*W+1:0] r_s3_sq [6];
    logic signed [W-1:0] r_s3_x0, r_s3_y0;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_xk   <= w_xk;
            r_s3_yk   <= w_yk;
            r_s3_mxs  <= w_mxs;
            r_s3_mys  <= w_mys;
            r_s3_s    <= w_s;
            r_s3_ua   <= w_ua;
            r_s3_va   <= w_va;
            r_s3_ub   <= w_ub;
            r_s3_vb   <= w_vb;
            r_s3_bx   <= r_s2_bx;
            r_s3_by   <= r_s2_by;
            r_s3_qx   <= r_s2_qx;
            r_s3_qy   <= r_s2_qy;
            r_s3_sq[0] <= r_s2_bx * r_s2_bx;
            r_s3_sq[1] <= r_s2_by * r_s2_by;
            r_s3_sq[2] <= r_s2_qx * r_s2_qx;
            r_s3_sq[3] <= r_s2_qy * r_s2_qy;
            r_s3_sq[4] <= r_s2_bx * r_s2_qy;
            r_s3_sq[5] <= r_s2_by * r_s2_qx;
            r_s3_x0   <= r_s2_x[0];
            r_s3_y0   <= r_s2_y[0];
        end
    end

    // stage 4: squared lengths, doubled cross product, bisector terms
    t_kind                 r_s4_xk, r_s4_yk;
    logic signed [W:0]     r_s4_mxs, r_s4_mys;
    logic signed [W:0]     r_s4_a, r_s4_du, r_s4_dv;
    logic signed [W+1:0]   r_s4_c;
    logic signed [2*W+2:0] r_s4_b2, r_s4_q2;
    logic signed [DW-1:0]  r_s4_den;
    logic signed [W:0]     r_s4_bx, r_s4_by, r_s4_qx, r_s4_qy;
    logic signed [W-1:0]   r_s4_x0, r_s4_y0;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_xk  <= r_s3_xk;
            r_s4_yk  <= r_s3_yk;
            r_s4_mxs <= r_s3_mxs;
            r_s4_mys <= r_s3_mys;
            r_s4_a   <= (W+1)'(r_s3_ua) + (W+1)'(r_s3_ub);
            r_s4_du  <= (W+1)'(r_s3_ub) - (W+1)'(r_s3_ua);
            r_s4_dv  <= (W+1)'(r_s3_vb) - (W+1)'(r_s3_va);
            r_s4_c   <= (W+2)'(r_s3_s) - (W+2)'(r_s3_va) - (W+2)'(r_s3_vb);
            r_s4_b2  <= (2*W+3)'(r_s3_sq[0]) + (2*W+3)'(r_s3_sq[1]);
            r_s4_q2  <= (2*W+3)'(r_s3_sq[2]) + (2*W+3)'(r_s3_sq[3]);
            r_s4_den <= (DW'(r_s3_sq[4]) - DW'(r_s3_sq[5])) <<< 1;
            r_s4_bx  <= r_s3_bx;
            r_s4_by  <= r_s3_by;
            r_s4_qx  <= r_s3_qx;
            r_s4_qy  <= r_s3_qy;
            r_s4_x0  <= r_s3_x0;
            r_s4_y0  <= r_s3_y0;
        end
    end

    // stage 5: split partial products of the wide terms
    // order: qy*b2, by*q2, x0*den, bx*q2, qx*b2, y0*den
    logic signed [W:0]    w_pa [6];
    logic signed [DW-1:0] w_pb [6];
    logic signed [W+1:0]  w_hi [6];
    logic signed [W+2:0]  w_lo [6];

    always_comb begin
        w_pa[0] = r_s4_qy;          w_pb[0] = DW'(r_s4_b2);
        w_pa[1] = r_s4_by;          w_pb[1] = DW'(r_s4_q2);
        w_pa[2] = (W+1)'(r_s4_x0);  w_pb[2] = r_s4_den;
        w_pa[3] = r_s4_bx;          w_pb[3] = DW'(r_s4_q2);
        w_pa[4] = r_s4_qx;          w_pb[4] = DW'(r_s4_b2);
        w_pa[5] = (W+1)'(r_s4_y0);  w_pb[5] = r_s4_den;
        for (int i = 0; i < 6; i++) begin
            w_hi[i] = $signed(w_pb[i][DW-1:L]);
            w_lo[i] = $signed({1'b0, w_pb[i][L-1:0]});
        end
    end

    t_kind                 r_s5_xk, r_s5_yk;
    logic signed [W:0]     r_s5_mxs, r_s5_mys;
    logic signed [2*W+1:0] r_s5_pa;
    logic signed [2*W+2:0] r_s5_pc;
    logic signed [W+1:0]   r_s5_dbis;
    logic signed [2*W+2:0] r_s5_phi [6];
    logic signed [2*W+3:0] r_s5_plo [6];
    logic signed [DW-1:0]  r_s5_den;
    logic signed [W-1:0]   r_s5_x0, r_s5_y0;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_xk   <= r_s4_xk;
            r_s5_yk   <= r_s4_yk;
            r_s5_mxs  <= r_s4_mxs;
            r_s5_mys  <= r_s4_mys;
            r_s5_pa   <= r_s4_a * r_s4_du;
            r_s5_pc   <= r_s4_c * r_s4_dv;
            r_s5_dbis <= (W+2)'(r_s4_du) <<< 1;
            for (int i = 0; i < 6; i++) begin
                r_s5_phi[i] <= w_pa[i] * w_hi[i];
                r_s5_plo[i] <= w_pa[i] * w_lo[i];
            end
            r_s5_den  <= r_s4_den;
            r_s5_x0   <= r_s4_x0;
            r_s5_y0   <= r_s4_y0;
        end
    end

    // stage 6: recombine partial products, bisector numerator
    t_kind                 r_s6_xk, r_s6_yk;
    logic signed [W:0]     r_s6_mxs, r_s6_mys;
    logic signed [2*W+3:0] r_s6_nb;
    logic signed [W+1:0]   r_s6_dbis;
    logic signed [NW-1:0]  r_s6_prod [6];
    logic signed [DW-1:0]  r_s6_den;
    logic signed [W-1:0]   r_s6_x0, r_s6_y0;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s6_xk   <= r_s5_xk;
            r_s6_yk   <= r_s5_yk;
            r_s6_mxs  <= r_s5_mxs;
            r_s6_mys  <= r_s5_mys;
            r_s6_nb   <= (2*W+4)'(r_s5_pa) - (2*W+4)'(r_s5_pc);
            r_s6_dbis <= r_s5_dbis;
            for (int i = 0; i < 6; i++) begin
                r_s6_prod[i] <= (NW'(r_s5_phi[i]) <<< L) + NW'(r_s5_plo[i]);
            end
            r_s6_den  <= r_s5_den;
            r_s6_x0   <= r_s5_x0;
            r_s6_y0   <= r_s5_y0;
        end
    end

    // stage 7: general circumcentre numerators
    t_kind                 r_s7_xk, r_s7_yk;
    logic signed [W:0]     r_s7_mxs, r_s7_mys;
    logic signed [2*W+3:0] r_s7_nb;
    logic signed [W+1:0]   r_s7_dbis;
    logic signed [NW-1:0]  r_s7_nxg, r_s7_nyg;
    logic signed [DW-1:0]  r_s7_den;
    logic signed [W-1:0]   r_s7_x0, r_s7_y0;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s7_xk   <= r_s6_xk;
            r_s7_yk   <= r_s6_yk;
            r_s7_mxs  <= r_s6_mxs;
            r_s7_mys  <= r_s6_mys;
            r_s7_nb   <= r_s6_nb;
            r_s7_dbis <= r_s6_dbis;
            r_s7_nxg  <= r_s6_prod[0] - r_s6_prod[1] + r_s6_prod[2];
            r_s7_nyg  <= r_s6_prod[3] - r_s6_prod[4] + r_s6_prod[5];
            r_s7_den  <= r_s6_den;
            r_s7_x0   <= r_s6_x0;
            r_s7_y0   <= r_s6_y0;
        end
    end

    // stage 8: pick numerator and divisor per axis
    logic signed [NW-1:0] w_nx, w_ny;
    logic signed [DW-1:0] w_dx, w_dy;

    always_comb begin
        case (r_s7_xk)
            KIND_MID: begin w_nx = NW'(r_s7_mxs); w_dx = DW'(2); end
            KIND_BIS: begin w_nx = NW'(r_s7_nb);  w_dx = DW'(r_s7_dbis); end
            KIND_GEN: begin w_nx = r_s7_nxg;      w_dx = r_s7_den; end
            default:  begin w_nx = '0;            w_dx = '0; end
        endcase
        case (r_s7_yk)
            KIND_MID: begin w_ny = NW'(r_s7_mys); w_dy = DW'(2); end
            KIND_BIS: begin w_ny = NW'(r_s7_nb);  w_dy = DW'(r_s7_dbis); end
            KIND_GEN: begin w_ny = r_s7_nyg;      w_dy = r_s7_den; end
            default:  begin w_ny = '0;            w_dy = '0; end
        endcase
    end

    logic signed [NW-1:0] r_s8_nx, r_s8_ny;
    logic signed [DW-1:0] r_s8_dx, r_s8_dy;
    t_dly                 r_s8_dly;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s8_nx      <= w_nx;
            r_s8_ny      <= w_ny;
            r_s8_dx      <= w_dx;
            r_s8_dy      <= w_dy;
            r_s8_dly.deg <= (w_dx == '0) || (w_dy == '0);
            r_s8_dly.x0  <= r_s7_x0;
            r_s8_dly.y0  <= r_s7_y0;
        end
    end

    // dividers, with the first point and flag riding alongside
    logic signed [W-1:0] w_cx, w_cy;
    logic                w_sat_x, w_sat_y;
    t_dly                r_dly [LAT];

    ccfp_div #(
        .CW (W),
        .NW (NW),
        .DW (DW)
    ) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_s8_nx),
        .i_den (r_s8_dx),
        .o_quo (w_cx),
        .o_sat (w_sat_x)
    );

    ccfp_div #(
        .CW (W),
        .NW (NW),
        .DW (DW)
    ) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_s8_ny),
        .i_den (r_s8_dy),
        .o_quo (w_cy),
        .o_sat (w_sat_y)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dly[0] <= r_s8_dly;
            for (int i = 1; i < LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // radius: offset, squares, sum
    t_side                 r_r1_side, r_r2_side;
    logic signed [W:0]     r_r1_rx, r_r1_ry;
    logic signed [2*W+1:0] r_r2_sx, r_r2_sy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r1_side.deg <= r_dly[LAT-1].deg;
            r_r1_side.sat <= w_sat_x | w_sat_y;
            r_r1_side.cx  <= w_cx;
            r_r1_side.cy  <= w_cy;
            r_r1_rx       <= (W+1)'(r_dly[LAT-1].x0) - (W+1)'(w_cx);
            r_r1_ry       <= (W+1)'(r_dly[LAT-1].y0) - (W+1)'(w_cy);
            r_r2_side     <= r_r1_side;
            r_r2_sx       <= r_r1_rx * r_r1_rx;
            r_r2_sy       <= r_r1_ry * r_r1_ry;
        end
    end

    // square root, one result bit per stage; remainder kept as n - root^2
    logic [RW-1:0]  r_sq_rem  [SQ+1];
    logic [W+1:0]   r_sq_root [SQ+1];
    t_side          r_sq_side [SQ+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_rem[0]  <= RW'($unsigned(r_r2_sx)) + RW'($unsigned(r_r2_sy));
            r_sq_root[0] <= '0;
            r_sq_side[0] <= r_r2_side;
        end
    end

    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        localparam int K = SQ - 1 - j;
        logic [RW-1:0] w_trial;
        logic          w_take;

        assign w_trial = (RW'(r_sq_root[j]) << (K + 1)) | (RW'(1) << (2 * K));
        assign w_take  = r_sq_rem[j] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_rem[j+1]  <= w_take ? r_sq_rem[j] - w_trial : r_sq_rem[j];
                r_sq_root[j+1] <= w_take ? (r_sq_root[j] | ((W+2)'(1) << K)) : r_sq_root[j];
                r_sq_side[j+1] <= r_sq_side[j];
            end
        end
    end

    // round to nearest, clamp and form the output beat
    logic [W+2:0] w_rr;
    logic         w_rsat;
    logic [W-1:0] w_rad;

    always_comb begin
        w_rr   = (W+3)'(r_sq_root[SQ]) + (W+3)'(r_sq_rem[SQ] > RW'(r_sq_root[SQ]));
        w_rsat = |w_rr[W+2:W];
        w_rad  = w_rsat ? '1 : w_rr[W-1:0];
    end

    logic [W-1:0] r_o_cx, r_o_cy, r_o_rad;
    logic         r_o_deg, r_o_sat;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_sq_side[SQ].deg) begin
                r_o_cx  <= '0;
                r_o_cy  <= '0;
                r_o_rad <= '0;
                r_o_deg <= 1'b1;
                r_o_sat <= 1'b0;
            end else begin
                r_o_cx  <= r_sq_side[SQ].cx;
                r_o_cy  <= r_sq_side[SQ].cy;
                r_o_rad <= w_rad;
                r_o_deg <= 1'b0;
                r_o_sat <= r_sq_side[SQ].sat | w_rsat;
            end
        end
    end

    always_comb begin
        m_axis_tdata          = '0;
        m_axis_tdata[3*W-1:0] = {r_o_rad, r_o_cy, r_o_cx};
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = {r_o_sat, r_o_deg};

endmodule

@@ hdl/ccfp_div.sv @@
// pipelined signed divider, rounded to nearest with ties away from zero, saturating
module ccfp_div #(
    parameter int CW = 32,
    parameter int NW = 102,
    parameter int DW = 68
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic signed [CW-1:0] o_quo,
    output logic                 o_sat
);

    localparam int EW = NW + 2;
    localparam logic [CW-1:0] HALF = CW'(1) << (CW - 1);

    logic [NW-1:0] w_an;
    logic [DW-1:0] w_ad;
    logic [EW-1:0] w_nn;
    logic [EW-1:0] w_dd;

    logic [EW-1:0] r_rem [CW+1];
    logic [DW:0]   r_dd  [CW+1];
    logic [CW-1:0] r_q   [CW+1];
    logic          r_neg [CW+1];
    logic          r_big [CW+1];

    logic signed [CW-1:0] r_quo;
    logic                 r_osat;

    // 2|n|+|d| over 2|d| gives the rounded magnitude
    always_comb begin
        w_an = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        w_ad = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
        w_nn = (EW'(w_an) << 1) + EW'(w_ad);
        w_dd = EW'(w_ad) << 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_nn;
            r_dd[0]  <= w_dd[DW:0];
            r_q[0]   <= '0;
            r_neg[0] <= i_num[NW-1] ^ i_den[DW-1];
            r_big[0] <= w_nn >= (w_dd << CW);
        end
    end

    for (genvar i = 0; i < CW; i++) begin : g_step
        localparam int K = CW - 1 - i;
        logic [EW-1:0] w_trial;
        logic          w_take;

        assign w_trial = EW'(r_dd[i]) << K;
        assign w_take  = r_rem[i] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= w_take ? r_rem[i] - w_trial : r_rem[i];
                r_q[i+1]   <= w_take ? (r_q[i] | (CW'(1) << K)) : r_q[i];
                r_dd[i+1]  <= r_dd[i];
                r_neg[i+1] <= r_neg[i];
                r_big[i+1] <= r_big[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[CW]) begin
                if (r_big[CW] || r_q[CW] > HALF) begin
                    r_quo  <= $signed(HALF);
                    r_osat <= 1'b1;
                end else begin
                    r_quo  <= $signed(CW'(0) - r_q[CW]);
                    r_osat <= 1'b0;
                end
            end else begin
                if (r_big[CW] || r_q[CW] >= HALF) begin
                    r_quo  <= $signed(~HALF);
                    r_osat <= 1'b1;
                end else begin
                    r_quo  <= $signed(r_q[CW]);
                    r_osat <= 1'b0;
                end
            end
        end
    end

    assign o_quo = r_quo;
    assign o_sat = r_osat;

endmodule

@@ tb/circumcircle_from_three_points_unit_tb.sv @@
// self-checking testbench for the circumcircle pipeline: random and directed triangles
module circumcircle_from_three_points_unit_tb
    import ccfp_pkg::*;
;

    localparam int      CW         = 32;
    localparam int      PIPE_DEPTH = 2 * CW + 16;
    localparam longint  CYCLE_CAP  = 1000000;
    localparam longint  S          = 65536;
    localparam longint  CMIN       = -(64'sd1 <<< 31);
    localparam longint  CMAX       = (64'sd1 <<< 31) - 1;

    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] rad;
        logic        degen;
        logic        sat;
    } circle_t;

    class circle_scoreboard;
        circle_t     pending[$];
        logic [15:0] tol;
        int          fails;

        function new();
            tol   = TOL_RESET;
            fails = 0;
        endfunction

        static function bit near(longint a, longint b, longint t);
            longint d;
            d = (a >= b) ? a - b : b - a;
            return d < t;
        endfunction

        static function void bisect(output wide_t n, output wide_t d, input longint s,
                                    input longint ua, va, ub, vb);
            wide_t du, dv, su, sv;
            du = ub - ua;
            dv = vb - va;
            su = ua + ub;
            sv = s - va - vb;
            n  = su * du - sv * dv;
            d  = 2 * du;
        endfunction

        // ties rounded away from zero
        static function wide_t div_round(wide_t n, wide_t d);
            logic [191:0] an, ad, q;
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            q  = (2 * an + ad) / (2 * ad);
            return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
        endfunction

        static function wide_t root_round(wide_t s);
            wide_t r, c;
            r = 0;
            for (int k = 35; k >= 0; k--) begin
                c = r | (wide_t'(1) <<< k);
                if (c * c <= s) r = c;
            end
            if (s - r * r > r) r = r + 1;
            return r;
        endfunction

        static function longint clamp(wide_t v, longint lo, longint hi, inout bit sat);
            if (v < lo) begin
                sat = 1;
                return lo;
            end
            if (v > hi) begin
                sat = 1;
                return hi;
            end
            return longint'(v);
        endfunction

        function void note_triangle(logic [191:0] d);
            longint  x[3], y[3], t, cx, cy, r;
            bit      v12, v20, v01, h12, h20, h01, sat;
            wide_t   nx, dx, ny, dy, bx, by, qx, qy, b2, q2, den, rx, ry;
            circle_t e;
            for (int i = 0; i < 3; i++) begin
                x[i] = $signed(d[64*i +: 32]);
                y[i] = $signed(d[64*i+32 +: 32]);
            end
            t   = tol;
            sat = 0;
            v12 = near(x[1], x[2], t); v20 = near(x[2], x[0], t); v01 = near(x[0], x[1], t);
            h12 = near(y[1], y[2], t); h20 = near(y[2], y[0], t); h01 = near(y[0], y[1], t);
            dx = 2;
            dy = 2;
            if (v12 && h20) begin
                nx = x[2] + x[0]; ny = y[1] + y[2];
            end else if (v20 && h01) begin
                nx = x[0] + x[1]; ny = y[2] + y[0];
            end else if (v01 && h12) begin
                nx = x[1] + x[2]; ny = y[0] + y[1];
            end else if (h12 && v20) begin
                nx = x[1] + x[2]; ny = y[2] + y[0];
            end else if (h20 && v01) begin
                nx = x[2] + x[0]; ny = y[0] + y[1];
            end else if (h01 && v12) begin
                nx = x[0] + x[1]; ny = y[1] + y[2];
            end else if (v12) begin
                ny = y[1] + y[2];
                bisect(nx, dx, y[1] + y[2], x[2], y[2], x[0], y[0]);
            end else if (v20) begin
                ny = y[2] + y[0];
                bisect(nx, dx, y[2] + y[0], x[1], y[1], x[2], y[2]);
            end else if (v01) begin
                ny = y[0] + y[1];
                bisect(nx, dx, y[0] + y[1], x[1], y[1], x[2], y[2]);
            end else if (h12) begin
                nx = x[1] + x[2];
                bisect(ny, dy, x[1] + x[2], y[2], x[2], y[0], x[0]);
            end else if (h20) begin
                nx = x[2] + x[0];
                bisect(ny, dy, x[2] + x[0], y[1], x[1], y[2], x[2]);
            end else if (h01) begin
                nx = x[0] + x[1];
                bisect(ny, dy, x[0] + x[1], y[1], x[1], y[2], x[2]);
            end else begin
                bx  = x[1] - x[0]; by = y[1] - y[0];
                qx  = x[2] - x[0]; qy = y[2] - y[0];
                b2  = bx * bx + by * by;
                q2  = qx * qx + qy * qy;
                den = 2 * (bx * qy - by * qx);
                nx  = qy * b2 - by * q2 + wide_t'(x[0]) * den;
                ny  = bx * q2 - qx * b2 + wide_t'(y[0]) * den;
                dx  = den;
                dy  = den;
            end
            if (dx == 0 || dy == 0) begin
                e = '{cx: '0, cy: '0, rad: '0, degen: 1'b1, sat: 1'b0};
            end else begin
                cx = clamp(div_round(nx, dx), CMIN, CMAX, sat);
                cy = clamp(div_round(ny, dy), CMIN, CMAX, sat);
                rx = x[0] - cx;
                ry = y[0] - cy;
                r  = clamp(root_round(rx * rx + ry * ry), 0, (64'sd1 <<< 32) - 1, sat);
                e  = '{cx: cx[31:0], cy: cy[31:0], rad: r[31:0], degen: 1'b0, sat: sat};
            end
            pending.push_back(e);
        endfunction

        function void check_circle(logic [95:0] data, logic [1:0] user);
            circle_t got, want;
            got = '{cx: data[31:0], cy: data[63:32], rad: data[95:64],
                    degen: user[0], sat: user[1]};
            if (pending.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result beat: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                fails++;
                if (fails <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_wr_en = 0;
    logic [15:0]  i_cfg_wr_data = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [95:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    circle_scoreboard sb = new();
    longint cycles = 0;
    bit     no_gaps = 0;
    bit     hold_req = 0;

    circumcircle_from_three_points_unit #(.COORD_WIDTH(CW)) dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_triangle(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_circle(m_axis_tdata, m_axis_tuser);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 0;
                repeat (600) @(posedge i_clk);
                hold_req = 0;
            end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 0;
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
                repeat (n - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    task automatic send_triangle(logic [191:0] d);
        int n;
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [15:0] v);
        i_cfg_wr_en   <= 1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 0;
        sb.tol = v;
    endtask

    function automatic logic [191:0] pack(longint x0, y0, x1, y1, x2, y2);
        return {y2[31:0], x2[31:0], y1[31:0], x1[31:0], y0[31:0], x0[31:0]};
    endfunction

    function automatic longint rand_coord();
        case ($urandom_range(0, 2))
            0:       return longint'($signed($urandom()));
            1:       return longint'($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return longint'($urandom_range(0, 1 << 26)) - (1 << 25);
        endcase
    endfunction

    function automatic logic [191:0] random_triangle();
        longint px[3], py[3], vx, vy, t;
        int     a, b, kind;
        t = sb.tol;
        for (int i = 0; i < 3; i++) begin
            px[i] = rand_coord();
            py[i] = rand_coord();
        end
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            // near-aligned chords: one or two axes, edges of the tolerance
            if (kind != 2) begin
                a = $urandom_range(0, 2); b = (a + $urandom_range(1, 2)) % 3;
                px[b] = px[a] + longint'($urandom_range(0, 2 * t + 4)) - (t + 2);
            end
            if (kind >= 2) begin
                a = $urandom_range(0, 2); b = (a + $urandom_range(1, 2)) % 3;
                py[b] = py[a] + longint'($urandom_range(0, 2 * t + 4)) - (t + 2);
            end
        end else if (kind == 6) begin
            vx = longint'($urandom_range(0, 1 << 16)) - (1 << 15);
            vy = longint'($urandom_range(0, 1 << 16)) - (1 << 15);
            px[1] = px[0] + vx * 2;  py[1] = py[0] + vy * 2;
            px[2] = px[0] - vx * 3;  py[2] = py[0] - vy * 3;
        end else if (kind == 7) begin
            a = $urandom_range(0, 2); b = (a + $urandom_range(1, 2)) % 3;
            px[b] = px[a]; py[b] = py[a];
        end
        return pack(px[0], py[0], px[1], py[1], px[2], py[2]);
    endfunction

    initial begin
        logic [15:0] tols[5];
        int          per_phase;
        tols[0] = TOL_RESET; tols[1] = 16'd0; tols[2] = 16'hFFFF; tols[3] = 16'd1;
        tols[4] = 16'($urandom_range(2, 4000));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed triangles at the reset tolerance
        send_triangle(pack(0, 0, 0, 0, 0, 0));
        send_triangle(pack(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_triangle(pack(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_triangle(pack(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX));
        send_triangle(pack(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
        send_triangle(pack(CMAX, 0, CMIN, 1, 0, CMAX));
        send_triangle(pack(0, 0, 5*S, 3*S, 5*S, 0));
        send_triangle(pack(0, 0, 3*S, 0, 0, 4*S));
        send_triangle(pack(0, 0, 0, 4*S, 3*S, 4*S));
        send_triangle(pack(0, 0, 4*S, 3*S, 0, 3*S));
        send_triangle(pack(0, 0, 0, 5*S, 3*S, 0));
        send_triangle(pack(0, 0, 3*S, 0, 3*S, 4*S));
        send_triangle(pack(0, 0, 4*S, S, 4*S, 3*S));
        send_triangle(pack(0, 0, 3*S, 5*S, 0, 2*S));
        send_triangle(pack(0, 0, 0, 3*S, 5*S, S));
        send_triangle(pack(0, 0, S, 4*S, 3*S, 4*S));
        send_triangle(pack(0, 0, 2*S, 5*S, 3*S, 0));
        send_triangle(pack(0, 0, 3*S, 0, S, 5*S));
        send_triangle(pack(123, -77, 3*S + 9, S, S - 5, 4*S));
        send_triangle(pack(0, 0, S, S, 2*S, 2*S));
        send_triangle(pack(0, 0, 0, S, 0, 3*S));
        send_triangle(pack(0, 0, 6, 5*S, 3*S, 9));
        send_triangle(pack(0, 0, 7, 100, 50, 7));
        drain();

        per_phase = 310;
        for (int p = 0; p < 5; p++) begin
            if (p != 0) write_tolerance(tols[p]);
            no_gaps = (p == 3);
            if (p == 2) hold_req = 1;
            for (int i = 0; i < per_phase; i++) send_triangle(random_triangle());
            // sender waits for every outstanding circle
            drain();
        end

        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
